// ===== design/skle_pkg.sv =====
`timescale 1ns / 1ps
// skle_pkg: shared types, widths and codes for the sorted key list engine
// no dependencies; imported by the cell and top-level modules

package skle_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int POS_W  = 4;
  localparam int KEY_W  = 10;
  localparam int PAY_W  = 32;
  localparam int ACT_W  = 3;
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // register word indexes
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_ORD_INSERT  = 3'd0,
    ACT_REMOVE_HEAD = 3'd1,
    ACT_REMOVE_AT   = 3'd2,
    ACT_INSERT_AT   = 3'd3,
    ACT_READ_AT     = 3'd4,
    ACT_INSERT_HEAD = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    cell_op_t               op;
    logic                   ordered;
    logic [POS_W-1:0]       pos;
    logic [KEY_W-1:0]       key;
    logic [PAY_W-1:0]       payload;
  } cell_ctl_t;

endpackage

// ===== design/skle_cell.sv =====
`timescale 1ns / 1ps
// skle_cell: one slot of the list, holding a key and payload
// depends on skle_pkg; shifts to or from its neighbors on insert and remove

module skle_cell (
  input  logic                       clk,
  input  logic [skle_pkg::IDX_W-1:0] cell_idx,
  input  skle_pkg::cell_ctl_t        ctl,
  input  logic [skle_pkg::CNT_W-1:0] count,
  input  logic                       search_in,
  input  logic [skle_pkg::KEY_W-1:0] left_key,
  input  logic [skle_pkg::PAY_W-1:0] left_payload,
  input  logic [skle_pkg::KEY_W-1:0] right_key,
  input  logic [skle_pkg::PAY_W-1:0] right_payload,
  output logic                       search_out,
  output logic [skle_pkg::KEY_W-1:0] key,
  output logic [skle_pkg::PAY_W-1:0] payload
);
  import skle_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] payload_r, payload_nxt;
  logic             occupied;
  logic             less;
  logic             ahead;
  logic             at_pos;

  assign occupied   = CNT_W'(cell_idx) < count;
  assign less       = occupied && (key_r < ctl.key);
  // search ripples while every slot so far holds a smaller key
  assign search_out = search_in && less;

  always_comb begin
    if (ctl.ordered) begin
      ahead  = search_out;
      at_pos = search_in && !less;
    end else begin
      ahead  = cell_idx < ctl.pos;
      at_pos = cell_idx == ctl.pos;
    end
  end

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (at_pos) begin
          key_nxt     = ctl.key;
          payload_nxt = ctl.payload;
        end else if (!ahead) begin
          key_nxt     = left_key;
          payload_nxt = left_payload;
        end
      end
      CELL_REMOVE: begin
        if (!ahead) begin
          key_nxt     = right_key;
          payload_nxt = right_payload;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign key     = key_r;
  assign payload = payload_r;

endmodule

// ===== design/sorted_key_list_engine_unit.sv =====
`timescale 1ns / 1ps
// sorted_key_list_engine_unit: top level of the sorted key list engine
// depends on skle_pkg and skle_cell

// A request is taken at any rising edge where start is high; busy never rises,
// so one request can be issued every cycle. Each request produces exactly one
// result, shown on the out_ ports for one cycle with out_strobe high, in the
// cycle right after the request was taken. The receiver cannot stall, so it
// must capture every strobe. The row of sixteen slot cells does the work:
// every cell decides locally (keep, shift from a neighbor, or load the new
// entry) and all update on the same edge, with the ordered-insert search
// rippling one bit from cell to cell. Positions are 0-based. The user must
// write capacity through the APB-style cfg_ port only while no request is in
// flight (unenforced); the limit in force is the smaller of capacity and 16.

module sorted_key_list_engine_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  logic [skle_pkg::ACT_W-1:0]  in_action,
  input  logic [skle_pkg::POS_W-1:0]  in_position,
  input  logic [skle_pkg::KEY_W-1:0]  in_entry_key,
  input  logic [skle_pkg::PAY_W-1:0]  in_entry_payload,
  // result channel
  output logic                        out_strobe,
  output logic                        out_ok,
  output logic [skle_pkg::CNT_W-1:0]  out_count_after,
  output logic [skle_pkg::KEY_W-1:0]  out_read_key,
  output logic [skle_pkg::PAY_W-1:0]  out_read_payload,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [skle_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [skle_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [skle_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import skle_pkg::*;

  // configuration and list bookkeeping
  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] limit;
  logic             accept;
  logic             cfg_write;
  logic             reg_sel;

  // result registers
  logic             strobe_r;
  logic             ok_r, ok_nxt;
  logic [CNT_W-1:0] count_after_r;
  logic [KEY_W-1:0] read_key_r, read_key_nxt;
  logic [PAY_W-1:0] read_payload_r, read_payload_nxt;

  // cell row
  cell_ctl_t        ctl;
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [PAY_W-1:0] cell_payload [DEPTH];
  logic [DEPTH:0]   search;

  action_t          act;
  logic             has_room;

  // no multi-cycle work, so the request side is never held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // apb: zero wait states, word index in the upper address bit
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[ADDR_W-1] == REG_CAPACITY;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel ? DATA_W'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_write && reg_sel) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  // limit in force is min(capacity, depth)
  assign limit    = (CNT_W'(capacity_r) > DEPTH_CNT) ? DEPTH_CNT : CNT_W'(capacity_r);
  assign has_room = count_r < limit;
  assign act      = action_t'(in_action);

  // decode the request into a broadcast for the cells plus the result
  always_comb begin
    ctl.op           = CELL_HOLD;
    ctl.ordered      = 1'b0;
    ctl.pos          = in_position;
    ctl.key          = in_entry_key;
    ctl.payload      = in_entry_payload;
    ok_nxt           = 1'b0;
    count_nxt        = count_r;
    read_key_nxt     = '0;
    read_payload_nxt = '0;
    unique case (act)
      ACT_ORD_INSERT: begin
        // insertion point comes from the search ripple, always within count
        ctl.ordered = 1'b1;
        ok_nxt      = has_room;
      end
      ACT_INSERT_AT: begin
        ok_nxt = has_room && (CNT_W'(in_position) <= count_r);
      end
      ACT_INSERT_HEAD: begin
        ctl.pos = '0;
        ok_nxt  = has_room;
      end
      ACT_REMOVE_HEAD: begin
        ctl.pos = '0;
        ok_nxt  = count_r != '0;
      end
      ACT_REMOVE_AT: begin
        ok_nxt = CNT_W'(in_position) < count_r;
      end
      ACT_READ_AT: begin
        ok_nxt = CNT_W'(in_position) < count_r;
        if (ok_nxt) begin
          read_key_nxt     = cell_key[in_position[IDX_W-1:0]];
          read_payload_nxt = cell_payload[in_position[IDX_W-1:0]];
        end
      end
      default: begin
        // unused codes change nothing and fail
      end
    endcase

    // only a successful, accepted insert or remove moves the cells
    if (accept && ok_nxt) begin
      if (act == ACT_ORD_INSERT || act == ACT_INSERT_AT || act == ACT_INSERT_HEAD) begin
        ctl.op    = CELL_INSERT;
        count_nxt = count_r + CNT_W'(1);
      end else if (act == ACT_REMOVE_HEAD || act == ACT_REMOVE_AT) begin
        ctl.op    = CELL_REMOVE;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // the row of slot cells; the ordered-insert search enters at slot zero
  assign search[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic [PAY_W-1:0] lp, rp;

    if (i == 0) begin : g_first
      assign lk = cell_key[i];
      assign lp = cell_payload[i];
    end else begin : g_mid_l
      assign lk = cell_key[i-1];
      assign lp = cell_payload[i-1];
    end

    // the last slot never has a live right neighbor
    if (i == DEPTH-1) begin : g_last
      assign rk = cell_key[i];
      assign rp = cell_payload[i];
    end else begin : g_mid_r
      assign rk = cell_key[i+1];
      assign rp = cell_payload[i+1];
    end

    skle_cell u_cell (
      .clk           (clk),
      .cell_idx      (IDX_W'(i)),
      .ctl           (ctl),
      .count         (count_r),
      .search_in     (search[i]),
      .left_key      (lk),
      .left_payload  (lp),
      .right_key     (rk),
      .right_payload (rp),
      .search_out    (search[i+1]),
      .key           (cell_key[i]),
      .payload       (cell_payload[i])
    );
  end

  // count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload, valid only with the strobe
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r           <= ok_nxt;
      count_after_r  <= count_nxt;
      read_key_r     <= read_key_nxt;
      read_payload_r <= read_payload_nxt;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_ok           = ok_r;
  assign out_count_after  = count_after_r;
  assign out_read_key     = read_key_r;
  assign out_read_payload = read_payload_r;

endmodule

// ===== design/skle_checker.sv =====
`timescale 1ns / 1ps
// skle_checker: port-level assertions for the sorted key list engine
// depends on skle_pkg; bound to sorted_key_list_engine_unit below

module skle_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [skle_pkg::ACT_W-1:0]  in_action,
  input logic                        out_strobe,
  input logic                        out_ok,
  input logic [skle_pkg::CNT_W-1:0]  out_count_after,
  input logic [skle_pkg::KEY_W-1:0]  out_read_key,
  input logic [skle_pkg::PAY_W-1:0]  out_read_payload
);
  import skle_pkg::*;

  // exactly one result per request, in the cycle after it
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_strobe == $past(start && !busy)))
    else $error("result strobe does not follow request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_count_after <= DEPTH_CNT))
    else $error("count exceeds depth");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_ok) |-> (out_read_key == '0 && out_read_payload == '0))
    else $error("failed request carries read data");

  // only read at may return data
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_action) != ACT_READ_AT)
      |-> (out_read_key == '0 && out_read_payload == '0))
    else $error("read data on a non-read request");

  // a count change must come from a successful request
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(out_strobe) && out_count_after != $past(out_count_after))
      |-> out_ok)
    else $error("count moved on a failed request");

endmodule

bind sorted_key_list_engine_unit skle_checker u_skle_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_action        (in_action),
  .out_strobe       (out_strobe),
  .out_ok           (out_ok),
  .out_count_after  (out_count_after),
  .out_read_key     (out_read_key),
  .out_read_payload (out_read_payload)
);
